FILE: rtl/pkd_pkg.sv
package pkd_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CFG_W     = 31;
	localparam int DAT_W     = 32;
	// quotient bits per divider, one per stage
	localparam int DIV_STEPS = 33;
	// five arithmetic stages, the divider stages, then the saturating output stage
	localparam int LAT       = 5 + DIV_STEPS + 1;

	localparam logic [1:0] REG_MASS = 2'd0;
	localparam logic [1:0] REG_STEP = 2'd1;
	localparam logic [1:0] REG_CELL = 2'd2;

	typedef struct packed {
		logic [CFG_W-1:0] mass;
		logic [CFG_W-1:0] step;
		logic [CFG_W-1:0] side;
	} pkd_cfg_t;

endpackage

FILE: rtl/pkd_in_if.sv
interface pkd_in_if;
	logic        valid;
	logic        ready;
	logic signed [pkd_pkg::DAT_W-1:0] force_x;
	logic signed [pkd_pkg::DAT_W-1:0] force_y;
	logic signed [pkd_pkg::DAT_W-1:0] force_z;
	logic signed [pkd_pkg::DAT_W-1:0] pos_x;
	logic signed [pkd_pkg::DAT_W-1:0] pos_y;
	logic signed [pkd_pkg::DAT_W-1:0] pos_z;
	logic signed [pkd_pkg::DAT_W-1:0] vel_x;
	logic signed [pkd_pkg::DAT_W-1:0] vel_y;
	logic signed [pkd_pkg::DAT_W-1:0] vel_z;

	modport source (output valid, force_x, force_y, force_z, pos_x, pos_y, pos_z,
		vel_x, vel_y, vel_z, input ready);
	modport sink (input valid, force_x, force_y, force_z, pos_x, pos_y, pos_z,
		vel_x, vel_y, vel_z, output ready);
endinterface

FILE: rtl/pkd_out_if.sv
interface pkd_out_if;
	logic        valid;
	logic        ready;
	logic signed [pkd_pkg::DAT_W-1:0] new_pos_x;
	logic signed [pkd_pkg::DAT_W-1:0] new_pos_y;
	logic signed [pkd_pkg::DAT_W-1:0] new_pos_z;
	logic signed [pkd_pkg::DAT_W-1:0] new_vel_x;
	logic signed [pkd_pkg::DAT_W-1:0] new_vel_y;
	logic signed [pkd_pkg::DAT_W-1:0] new_vel_z;
	logic [2:0]  axis_clamped;

	modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x,
		new_vel_y, new_vel_z, axis_clamped, input ready);
	modport sink (input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x,
		new_vel_y, new_vel_z, axis_clamped, output ready);
endinterface

FILE: rtl/pkd_lane.sv
module pkd_lane (
	input  logic                                clk,
	input  logic [pkd_pkg::LAT-1:0]             en,
	input  pkd_pkg::pkd_cfg_t                   cfg,
	input  logic signed [pkd_pkg::DAT_W-1:0]    f,
	input  logic signed [pkd_pkg::DAT_W-1:0]    p,
	input  logic signed [pkd_pkg::DAT_W-1:0]    v,
	output logic signed [pkd_pkg::DAT_W-1:0]    np,
	output logic signed [pkd_pkg::DAT_W-1:0]    nv,
	output logic                                clamp
);

	localparam int CW  = pkd_pkg::CFG_W;
	localparam int DW  = pkd_pkg::DAT_W;
	localparam int NS  = pkd_pkg::DIV_STEPS;
	localparam int PW  = 96;              // displacement numerator width
	localparam int FW  = DW + CW;         // |f| * t width
	localparam int QW  = NS;
	localparam int SW  = DW + 3;          // width of the saturating sums

	typedef struct packed {
		logic signed [DW-1:0] p;
		logic signed [DW-1:0] v;
		logic                 vneg;
		logic                 fneg;
		logic                 dneg;
		logic                 big;
		logic                 clamp;
	} ctl_t;

	function automatic logic signed [DW-1:0] sat(input logic signed [SW-1:0] r);
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] lo;
		hi = SW'(signed'({1'b0, {(DW-1){1'b1}}}));
		lo = -hi - SW'(1);
		if (r > hi)
			sat = {1'b0, {(DW-1){1'b1}}};
		else if (r < lo)
			sat = {1'b1, {(DW-1){1'b0}}};
		else
			sat = r[DW-1:0];
	endfunction

	logic [CW-1:0] m_eff;
	logic [CW:0]   two_m;
	logic [DW-1:0] magv, magf;
	logic [PW-1:0] den;

	assign m_eff = (cfg.mass == '0) ? CW'(1) : cfg.mass;
	assign two_m = {m_eff, 1'b0};
	assign magv  = v[DW-1] ? (~v + DW'(1)) : v;
	assign magf  = f[DW-1] ? (~f + DW'(1)) : f;
	assign den   = PW'(two_m) << pkd_pkg::FRAC_BITS;

	// s1: 2m*|v|, |f|*t, side*2m
	logic [2*DW-1:0] a_s1;
	logic [FW-1:0]   ft_s1, lim_s1;
	ctl_t            c_s1;
	always_ff @(posedge clk) begin
		if (en[0]) begin
			a_s1   <= (2*DW)'(two_m) * (2*DW)'(magv);
			ft_s1  <= FW'(magf) * FW'(cfg.step);
			lim_s1 <= FW'(cfg.side) * FW'(two_m);
			c_s1   <= '{p: p, v: v, vneg: v[DW-1], fneg: f[DW-1], dneg: 1'b0,
				big: 1'b0, clamp: 1'b0};
		end
	end

	// s2: partial products against the time step
	logic [FW-1:0] alt_s2, aht_s2, flt_s2, fht_s2, ft_s2, lim_s2;
	ctl_t          c_s2;
	always_ff @(posedge clk) begin
		if (en[1]) begin
			alt_s2 <= FW'(a_s1[DW-1:0]) * FW'(cfg.step);
			aht_s2 <= FW'(a_s1[2*DW-1:DW]) * FW'(cfg.step);
			flt_s2 <= FW'(ft_s1[DW-1:0]) * FW'(cfg.step);
			fht_s2 <= FW'(ft_s1[FW-1:DW]) * FW'(cfg.step);
			ft_s2  <= ft_s1;
			lim_s2 <= lim_s1;
			// velocity step of 2^33 or more saturates whatever v is
			c_s2   <= '{p: c_s1.p, v: c_s1.v, vneg: c_s1.vneg, fneg: c_s1.fneg,
				dneg: c_s1.dneg, big: (FW'(ft_s1 >> QW) >= FW'(m_eff)),
				clamp: c_s1.clamp};
		end
	end

	// s3: assemble v*t*2m and f*t*t
	logic [PW-1:0] t1_s3, t2_s3;
	logic [FW-1:0] ft_s3, lim_s3;
	ctl_t          c_s3;
	always_ff @(posedge clk) begin
		if (en[2]) begin
			t1_s3  <= (PW'(aht_s2) << DW) + PW'(alt_s2);
			t2_s3  <= (PW'(fht_s2) << DW) + PW'(flt_s2);
			ft_s3  <= ft_s2;
			lim_s3 <= lim_s2;
			c_s3   <= c_s2;
		end
	end

	// s4: signed displacement as magnitude and sign
	logic [PW-1:0] dm_c;
	logic          dneg_c;
	always_comb begin
		if (c_s3.vneg == c_s3.fneg) begin
			dm_c   = t1_s3 + t2_s3;
			dneg_c = c_s3.vneg;
		end else if (t1_s3 >= t2_s3) begin
			dm_c   = t1_s3 - t2_s3;
			dneg_c = c_s3.vneg;
		end else begin
			dm_c   = t2_s3 - t1_s3;
			dneg_c = c_s3.fneg;
		end
	end

	logic [PW-1:0] dm_s4;
	logic [FW-1:0] ft_s4, lim_s4;
	ctl_t          c_s4;
	always_ff @(posedge clk) begin
		if (en[3]) begin
			ft_s4  <= ft_s3;
			lim_s4 <= lim_s3;
			dm_s4  <= dm_c;
			c_s4   <= '{p: c_s3.p, v: c_s3.v, vneg: c_s3.vneg, fneg: c_s3.fneg,
				dneg: dneg_c, big: c_s3.big, clamp: c_s3.clamp};
		end
	end

	// s5: bound test against cell side, exact
	logic [PW-1:0] dm_s5;
	logic [FW-1:0] ft_s5;
	ctl_t          c_s5;
	always_ff @(posedge clk) begin
		if (en[4]) begin
			dm_s5      <= dm_s4;
			ft_s5      <= ft_s4;
			c_s5       <= '{p: c_s4.p, v: c_s4.v, vneg: c_s4.vneg, fneg: c_s4.fneg,
				dneg: c_s4.dneg, big: c_s4.big,
				clamp: (dm_s4 >= (PW'(lim_s4) << pkd_pkg::FRAC_BITS))};
		end
	end

	// two restoring dividers side by side, one quotient bit per stage, MSB first
	logic [PW-1:0] pr_d [NS];
	logic [QW-1:0] pq_d [NS];
	logic [FW-1:0] vr_d [NS];
	logic [QW-1:0] vq_d [NS];
	ctl_t          c_d  [NS];

	for (genvar j = 0; j < NS; j++) begin : g_div
		localparam int K = NS - 1 - j;
		logic [PW-1:0] pr_in, pr_sh;
		logic [QW-1:0] pq_in, vq_in;
		logic [FW-1:0] vr_in, vr_sh;
		ctl_t          c_in;
		if (j == 0) begin : g_first
			assign pr_in = dm_s5;
			assign pq_in = '0;
			assign vr_in = ft_s5;
			assign vq_in = '0;
			assign c_in  = c_s5;
		end else begin : g_next
			assign pr_in = pr_d[j-1];
			assign pq_in = pq_d[j-1];
			assign vr_in = vr_d[j-1];
			assign vq_in = vq_d[j-1];
			assign c_in  = c_d[j-1];
		end
		assign pr_sh = den << K;
		assign vr_sh = FW'(m_eff) << K;
		always_ff @(posedge clk) begin
			if (en[5+j]) begin
				c_d[j] <= c_in;
				if (pr_in >= pr_sh) begin
					pr_d[j] <= pr_in - pr_sh;
					pq_d[j] <= pq_in | (QW'(1) << K);
				end else begin
					pr_d[j] <= pr_in;
					pq_d[j] <= pq_in;
				end
				if (vr_in >= vr_sh) begin
					vr_d[j] <= vr_in - vr_sh;
					vq_d[j] <= vq_in | (QW'(1) << K);
				end else begin
					vr_d[j] <= vr_in;
					vq_d[j] <= vq_in;
				end
			end
		end
	end

	// output stage: apply steps with saturation, or revert a clamped axis
	ctl_t                 cl;
	logic signed [SW-1:0] pe, ve, qp, qv, rp, rv;
	assign cl = c_d[NS-1];
	assign pe = SW'(cl.p);
	assign ve = SW'(cl.v);
	assign qp = SW'(signed'({1'b0, pq_d[NS-1]}));
	assign qv = SW'(signed'({1'b0, vq_d[NS-1]}));
	assign rp = cl.dneg ? pe - qp : pe + qp;
	assign rv = cl.fneg ? ve - qv : ve + qv;

	always_ff @(posedge clk) begin
		if (en[pkd_pkg::LAT-1]) begin
			clamp <= cl.clamp;
			if (cl.clamp) begin
				np <= cl.p;
				nv <= cl.v;
			end else begin
				np <= sat(rp);
				if (cl.big)
					nv <= cl.fneg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
				else
					nv <= sat(rv);
			end
		end
	end

endmodule

FILE: rtl/particle_kinematic_update_unit.sv
// Kinematic step for one particle per beat: three identical axis lanes compute
// the new position and velocity from force, position and velocity in signed
// Q16.16, and the output stage gathers the three axes and their clamp flags
// into one result beat. A beat is accepted every cycle unless a stalled output
// has filled the pipeline of five multiply and add stages, 33 stages of the two
// restoring dividers in each lane and one saturation stage. Every stage holds its
// own valid bit, so a stalled output only blocks input once the pipeline has no
// bubble left. Mass, time step and cell side are written over the APB port at
// byte addresses 0, 4 and 8 and must be left alone while beats are in flight.
module particle_kinematic_update_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	pkd_in_if.sink      in_ch,
	pkd_out_if.source   out_ch
);

	localparam int L  = pkd_pkg::LAT;
	localparam int CW = pkd_pkg::CFG_W;

	logic [CW-1:0]     mass_q, step_q, cell_q;
	pkd_pkg::pkd_cfg_t cfg;
	logic [L-1:0]      vld_q;
	logic [L-1:0]      stg_en;
	logic              wr;
	logic [2:0]        clamp;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= CW'(65536);
			step_q <= CW'(6554);
			cell_q <= CW'(65536);
		end else if (wr) begin
			unique case (paddr[3:2])
				pkd_pkg::REG_MASS: mass_q <= pwdata[CW-1:0];
				pkd_pkg::REG_STEP: step_q <= pwdata[CW-1:0];
				pkd_pkg::REG_CELL: cell_q <= pwdata[CW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			pkd_pkg::REG_MASS: prdata = {1'b0, mass_q};
			pkd_pkg::REG_STEP: prdata = {1'b0, step_q};
			pkd_pkg::REG_CELL: prdata = {1'b0, cell_q};
			default:           prdata = '0;
		endcase
	end

	assign cfg = '{mass: mass_q, step: step_q, side: cell_q};

	// a stage may load when empty or when the stage after it moves
	always_comb begin
		stg_en[L-1] = !vld_q[L-1] || out_ch.ready;
		for (int i = L - 2; i >= 0; i--)
			stg_en[i] = !vld_q[i] || stg_en[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (stg_en[0])
				vld_q[0] <= in_ch.valid;
			for (int i = 1; i < L; i++)
				if (stg_en[i])
					vld_q[i] <= vld_q[i-1];
		end
	end

	assign in_ch.ready = stg_en[0];

	pkd_lane u_lane_x (
		.clk(clk), .en(stg_en), .cfg(cfg),
		.f(in_ch.force_x), .p(in_ch.pos_x), .v(in_ch.vel_x),
		.np(out_ch.new_pos_x), .nv(out_ch.new_vel_x), .clamp(clamp[0])
	);

	pkd_lane u_lane_y (
		.clk(clk), .en(stg_en), .cfg(cfg),
		.f(in_ch.force_y), .p(in_ch.pos_y), .v(in_ch.vel_y),
		.np(out_ch.new_pos_y), .nv(out_ch.new_vel_y), .clamp(clamp[1])
	);

	pkd_lane u_lane_z (
		.clk(clk), .en(stg_en), .cfg(cfg),
		.f(in_ch.force_z), .p(in_ch.pos_z), .v(in_ch.vel_z),
		.np(out_ch.new_pos_z), .nv(out_ch.new_vel_z), .clamp(clamp[2])
	);

	assign out_ch.axis_clamped = clamp;
	assign out_ch.valid        = vld_q[L-1];

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> vld_q[0])
		else $error("accepted beat did not enter first stage");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[0] |-> in_ch.ready)
		else $error("input refused with empty first stage");

	a_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[0] && !stg_en[1]) |-> !in_ch.ready)
		else $error("input taken while first stage is blocked");

endmodule

FILE: tb/kin_checker.sv
`timescale 1ns / 1ps
module kin_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [30:0] mass,
	input  logic [30:0] step,
	input  logic [30:0] side,
	pkd_in_if.sink      in_mon,
	pkd_out_if.sink     out_mon,
	output int          n_fail,
	output int          n_pending,
	output logic        any_beat
);

	typedef struct packed {
		logic signed [31:0] px, py, pz, vx, vy, vz;
		logic [2:0]         clamp;
	} kin_res_t;

	kin_res_t expected_q[$];

	function automatic logic signed [31:0] sat32(logic signed [127:0] v);
		if (v > 128'sd2147483647) return 32'sh7fffffff;
		if (v < -128'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// one axis: returns clamp flag, new position and velocity through outputs
	function automatic logic axis_update(logic signed [31:0] f, logic signed [31:0] p,
			logic signed [31:0] v, output logic signed [31:0] np,
			output logic signed [31:0] nv);
		logic signed [127:0] m, t, den, d, dabs, q, ft, dv;
		m = (mass == 0) ? 128'sd1 : $signed({97'd0, mass});
		t = $signed({97'd0, step});
		den = (2 * m) <<< pkd_pkg::FRAC_BITS;
		// exact displacement scaled by den: 2m*v*t + F*t*t
		d = 2 * m * v * t + f * t * t;
		dabs = d < 0 ? -d : d;
		if (dabs >= $signed({97'd0, side}) * den) begin
			np = p;
			nv = v;
			return 1'b1;
		end
		q = dabs / den;
		np = sat32(d < 0 ? p - q : p + q);
		ft = (f < 0 ? -f : f) * t;
		dv = ft / m;
		nv = sat32(f < 0 ? v - dv : v + dv);
		return 1'b0;
	endfunction

	function automatic kin_res_t predict_step(logic signed [31:0] fx, fy, fz,
			px, py, pz, vx, vy, vz);
		kin_res_t r;
		r.clamp[0] = axis_update(fx, px, vx, r.px, r.vx);
		r.clamp[1] = axis_update(fy, py, vy, r.py, r.vy);
		r.clamp[2] = axis_update(fz, pz, vz, r.pz, r.vz);
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s expected %h got %h", name, exp_v, act_v);
			n_fail++;
		end
	endtask

	assign n_pending = expected_q.size();
	assign any_beat = (in_mon.valid && in_mon.ready) || (out_mon.valid && out_mon.ready);

	always @(posedge clk) begin
		kin_res_t e;
		if (arst_n) begin
			if (out_mon.valid && out_mon.ready) begin
				if (expected_q.size() == 0) begin
					$error("result beat with nothing expected");
					n_fail++;
				end else begin
					e = expected_q.pop_front();
					check_field("new_pos_x", e.px, out_mon.new_pos_x);
					check_field("new_pos_y", e.py, out_mon.new_pos_y);
					check_field("new_pos_z", e.pz, out_mon.new_pos_z);
					check_field("new_vel_x", e.vx, out_mon.new_vel_x);
					check_field("new_vel_y", e.vy, out_mon.new_vel_y);
					check_field("new_vel_z", e.vz, out_mon.new_vel_z);
					check_field("axis_clamped", {29'd0, e.clamp},
						{29'd0, out_mon.axis_clamped});
				end
			end
			if (in_mon.valid && in_mon.ready)
				expected_q.push_back(predict_step(in_mon.force_x, in_mon.force_y,
					in_mon.force_z, in_mon.pos_x, in_mon.pos_y, in_mon.pos_z,
					in_mon.vel_x, in_mon.vel_y, in_mon.vel_z));
		end else begin
			n_fail = 0;
		end
	end
endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;

	localparam int WATCHDOG = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic [30:0] mass_shadow = 31'd65536, step_shadow = 31'd6554, cell_shadow = 31'd65536;
	int          n_fail, n_pending;
	int          idle_cycles = 0;
	logic        any_beat;
	int          src_idle_pct = 0, snk_stall_pct = 0, hold_off = 0;
	logic        hold_go = 1'b0;

	pkd_in_if  in_ch ();
	pkd_out_if out_ch ();

	always #5 clk = ~clk;

	particle_kinematic_update_unit u_top (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	kin_checker u_chk (
		.clk, .arst_n, .mass(mass_shadow), .step(step_shadow), .side(cell_shadow),
		.in_mon(in_ch.sink), .out_mon(out_ch.sink), .n_fail, .n_pending, .any_beat
	);

	initial begin
		in_ch.valid = 1'b0;
		{in_ch.force_x, in_ch.force_y, in_ch.force_z} = '0;
		{in_ch.pos_x, in_ch.pos_y, in_ch.pos_z} = '0;
		{in_ch.vel_x, in_ch.vel_y, in_ch.vel_z} = '0;
		out_ch.ready = 1'b0;
	end

	// receiver: random stalls, or a long counted hold-off
	always @(posedge clk) begin
		if (hold_go) begin
			hold_off <= 199;
			out_ch.ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ch.ready <= 1'b0;
		end else
			out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		if (any_beat || !arst_n || n_pending == 0 && !in_ch.valid) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [30:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= {1'($urandom_range(1)), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			pkd_pkg::REG_MASS: mass_shadow = val;
			pkd_pkg::REG_STEP: step_shadow = val;
			default:           cell_shadow = val;
		endcase
	endtask

	task automatic drain();
		while (n_pending != 0) @(posedge clk);
		repeat (pkd_pkg::LAT + 5) @(posedge clk);
	endtask

	function automatic logic [31:0] pick32();
		case ($urandom_range(7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(1) ? 32'hffffffff : 32'h0;
			3, 4: return $urandom_range(2 * 65536) - 65536;
			5: return $urandom_range(64 * 65536) - 32 * 65536;
			default: return $urandom;
		endcase
	endfunction

	task automatic send(logic [31:0] f[3], logic [31:0] p[3], logic [31:0] v[3]);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.force_x <= f[0]; in_ch.force_y <= f[1]; in_ch.force_z <= f[2];
		in_ch.pos_x <= p[0]; in_ch.pos_y <= p[1]; in_ch.pos_z <= p[2];
		in_ch.vel_x <= v[0]; in_ch.vel_y <= v[1]; in_ch.vel_z <= v[2];
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic send_random(int n);
		logic [31:0] f[3], p[3], v[3];
		for (int i = 0; i < n; i++) begin
			foreach (f[k]) begin
				f[k] = pick32(); p[k] = pick32(); v[k] = pick32();
			end
			send(f, p, v);
		end
		in_ch.valid <= 1'b0;
	endtask

	task automatic send_directed();
		logic [31:0] ext[4] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
		logic [31:0] f[3], p[3], v[3];
		for (int i = 0; i < 16; i++) begin
			f = '{ext[i % 4], ext[(i / 4) % 4], 32'h00010000};
			p = '{ext[(i + 1) % 4], ext[(i + 2) % 4], 32'h0};
			v = '{ext[(i / 4) % 4], ext[i % 4], 32'h00008000};
			send(f, p, v);
		end
		// small displacements over the cell bound on every axis
		f = '{32'h0, 32'hfff00000, 32'h00100000};
		p = '{32'h7fff0000, 32'h80010000, 32'h00000100};
		v = '{32'h0009ffff, 32'hfff60000, 32'h000a0000};
		send(f, p, v);
		in_ch.valid <= 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_directed();
		drain();

		// pressure: long hold-off while the sender keeps offering
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		send_random(100);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin reg_write(pkd_pkg::REG_MASS, 31'd1);
					reg_write(pkd_pkg::REG_STEP, 31'h7fffffff);
					reg_write(pkd_pkg::REG_CELL, 31'h7fffffff); end
				1: begin reg_write(pkd_pkg::REG_MASS, 31'h7fffffff);
					reg_write(pkd_pkg::REG_STEP, 31'd1);
					reg_write(pkd_pkg::REG_CELL, 31'd1); end
				2: begin reg_write(pkd_pkg::REG_MASS, 31'd0);
					reg_write(pkd_pkg::REG_STEP, 31'd65536);
					reg_write(pkd_pkg::REG_CELL, 31'd0); end
				3: begin reg_write(pkd_pkg::REG_MASS, 31'd65536);
					reg_write(pkd_pkg::REG_STEP, 31'd6554);
					reg_write(pkd_pkg::REG_CELL, 31'h7fffffff); end
				default: begin
					reg_write(pkd_pkg::REG_MASS, 31'($urandom_range(32'h0100_0000, 1)));
					reg_write(pkd_pkg::REG_STEP, 31'($urandom_range(32'h0004_0000, 1)));
					reg_write(pkd_pkg::REG_CELL, 31'($urandom_range(32'h0100_0000, 1)));
				end
			endcase
			case (ph % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 56; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 56; end
				default: begin src_idle_pct = 7; snk_stall_pct = 7; end
			endcase
			send_random(185);
			drain();
		end
		if (n_fail == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
